### design/spwt_pkg.sv
// Package for the signed pulse-width thermometer decoder.
// Holds the conversion phase type, register indexes, the decode event struct and field widths.
// Has no dependencies.
package spwt_pkg;

   localparam int unsigned COUNT_WIDTH = 16;
   localparam int unsigned MAG_WIDTH   = 14;

   localparam logic [COUNT_WIDTH-1:0] START_TIMEOUT_RESET   = 16'd65000;
   localparam logic [COUNT_WIDTH-1:0] MAX_PULSE_COUNT_RESET = 16'd10000;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_WAIT  = 2'd1,
      PHASE_PULSE = 2'd2
   } phase_type;

   typedef enum logic {
      REG_START_TIMEOUT   = 1'b0,
      REG_MAX_PULSE_COUNT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic                   valid;
      logic [COUNT_WIDTH-1:0] width;
      logic                   negative;
      logic                   timed_out;
   } spwt_event_type;

endpackage

### design/spwt_decoder.sv
// Conversion state machine of the signed pulse-width thermometer decoder.
// Tracks the phase, sample count and sign, and flags the request that ends a conversion.
// Depends on spwt_pkg.
module spwt_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             take,
   input  logic                             mode,
   input  logic                             plus_line,
   input  logic                             minus_line,
   input  logic [spwt_pkg::COUNT_WIDTH-1:0] start_timeout,
   input  logic [spwt_pkg::COUNT_WIDTH-1:0] max_pulse_count,
   output spwt_pkg::spwt_event_type         event_out
);

   spwt_pkg::phase_type              phase_ff, phase_in;
   logic [spwt_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic                             sign_ff, sign_in;
   logic                             active;
   logic [spwt_pkg::COUNT_WIDTH:0]   next_k;

   assign active = plus_line | minus_line;
   assign next_k = {1'b0, count_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= spwt_pkg::PHASE_IDLE;
         count_ff <= '0;
         sign_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sign_ff  <= sign_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      sign_in   = sign_ff;
      event_out = '0;
      if (take) begin
         if (mode) begin
            phase_in = spwt_pkg::PHASE_WAIT;
            count_in = '0;
            sign_in  = 1'b0;
         end else begin
            case (phase_ff)
               spwt_pkg::PHASE_WAIT: begin
                  if (!active) begin
                     if (count_ff >= start_timeout) begin
                        event_out.valid     = 1'b1;
                        event_out.negative  = 1'b1;
                        event_out.timed_out = 1'b1;
                        phase_in            = spwt_pkg::PHASE_IDLE;
                        count_in            = '0;
                     end else begin
                        count_in = next_k[spwt_pkg::COUNT_WIDTH-1:0];
                     end
                  end else begin
                     sign_in  = minus_line;
                     count_in = '0;
                     if (max_pulse_count == '0) begin
                        event_out.valid    = 1'b1;
                        event_out.negative = minus_line;
                        phase_in           = spwt_pkg::PHASE_IDLE;
                     end else begin
                        phase_in = spwt_pkg::PHASE_PULSE;
                     end
                  end
               end
               spwt_pkg::PHASE_PULSE: begin
                  if (!active) begin
                     event_out.valid    = 1'b1;
                     event_out.width    = next_k[spwt_pkg::COUNT_WIDTH-1:0];
                     event_out.negative = sign_ff;
                     phase_in           = spwt_pkg::PHASE_IDLE;
                     count_in           = '0;
                  end else if (next_k >= {1'b0, max_pulse_count}) begin
                     event_out.valid    = 1'b1;
                     event_out.negative = sign_ff;
                     phase_in           = spwt_pkg::PHASE_IDLE;
                     count_in           = '0;
                  end else begin
                     count_in = next_k[spwt_pkg::COUNT_WIDTH-1:0];
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   a_event_needs_take: assert property (@(posedge clock) disable iff (reset)
      event_out.valid |-> take)
      else $error("Conversion ended without an accepted request.");

   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      take && mode |=> phase_ff == spwt_pkg::PHASE_WAIT && count_ff == '0)
      else $error("Start request did not arm a fresh conversion.");

   a_event_returns_idle: assert property (@(posedge clock) disable iff (reset)
      event_out.valid |=> phase_ff == spwt_pkg::PHASE_IDLE)
      else $error("Phase not idle after a conversion ended.");

   a_timeout_shape: assert property (@(posedge clock) disable iff (reset)
      event_out.valid && event_out.timed_out |->
         event_out.width == '0 && event_out.negative)
      else $error("Timeout result has a width or lacks the negative flag.");

endmodule

### design/signed_pulse_width_thermometer.sv
// Signed pulse-width thermometer decoder: one sample request may be accepted every cycle
// while req_ready is high. A request that ends a conversion yields its result through an
// event register and then a result register holding the width * 19 / 100 scaling multiply;
// the two registers also absorb stalls on the result side. Depends on spwt_pkg, spwt_decoder.
module signed_pulse_width_thermometer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic                           req_plus_line,
   input  logic                           req_minus_line,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [spwt_pkg::MAG_WIDTH-1:0] rsp_magnitude,
   output logic                           rsp_negative,
   output logic                           rsp_timed_out,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [2:0]                     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   // floor(w * 19 / 100) equals (w * SCALE_MULT) >> SCALE_SHIFT for every 16-bit w.
   localparam int unsigned SCALE_SHIFT = 24;
   localparam int unsigned MULT_WIDTH  = 22;
   localparam int unsigned PROD_WIDTH  = spwt_pkg::COUNT_WIDTH + MULT_WIDTH;
   localparam logic [MULT_WIDTH-1:0] SCALE_MULT = 22'd3187672;

   logic [spwt_pkg::COUNT_WIDTH-1:0] start_timeout_ff, max_pulse_ff;
   logic                             csr_write;
   logic                             take;
   spwt_pkg::spwt_event_type         decode_event;
   logic                             s1_valid_ff, s1_valid_in;
   logic [spwt_pkg::COUNT_WIDTH-1:0] s1_width_ff;
   logic                             s1_negative_ff, s1_timed_out_ff;
   logic                             s1_ready, s2_ready;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [spwt_pkg::MAG_WIDTH-1:0]   magnitude_ff;
   logic                             negative_ff, timed_out_ff;
   logic [PROD_WIDTH-1:0]            product;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_timeout_ff <= spwt_pkg::START_TIMEOUT_RESET;
         max_pulse_ff     <= spwt_pkg::MAX_PULSE_COUNT_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            spwt_pkg::REG_START_TIMEOUT: begin
               start_timeout_ff <= pwdata[spwt_pkg::COUNT_WIDTH-1:0];
            end
            spwt_pkg::REG_MAX_PULSE_COUNT: begin
               max_pulse_ff <= pwdata[spwt_pkg::COUNT_WIDTH-1:0];
            end
            default: begin
               start_timeout_ff <= start_timeout_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         spwt_pkg::REG_START_TIMEOUT:   prdata = {16'd0, start_timeout_ff};
         spwt_pkg::REG_MAX_PULSE_COUNT: prdata = {16'd0, max_pulse_ff};
         default:                       prdata = '0;
      endcase
   end

   assign s2_ready  = ~rsp_valid_ff | rsp_ready;
   assign s1_ready  = ~s1_valid_ff | s2_ready;
   assign req_ready = s1_ready;
   assign take      = req_valid & req_ready;

   spwt_decoder u_decoder (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .mode            (req_mode),
      .plus_line       (req_plus_line),
      .minus_line      (req_minus_line),
      .start_timeout   (start_timeout_ff),
      .max_pulse_count (max_pulse_ff),
      .event_out       (decode_event)
   );

   assign s1_valid_in  = s1_ready ? decode_event.valid : s1_valid_ff;
   assign rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && decode_event.valid) begin
         s1_width_ff     <= decode_event.width;
         s1_negative_ff  <= decode_event.negative;
         s1_timed_out_ff <= decode_event.timed_out;
      end
   end

   assign product = {{MULT_WIDTH{1'b0}}, s1_width_ff}
                  * {{spwt_pkg::COUNT_WIDTH{1'b0}}, SCALE_MULT};

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         magnitude_ff <= product[SCALE_SHIFT +: spwt_pkg::MAG_WIDTH];
         negative_ff  <= s1_negative_ff;
         timed_out_ff <= s1_timed_out_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = magnitude_ff;
   assign rsp_negative  = negative_ff;
   assign rsp_timed_out = timed_out_ff;

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff)
      else $error("Request stalled while a result stage was free.");

   a_timeout_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |-> rsp_magnitude == '0 && rsp_negative)
      else $error("Timeout result carries a magnitude or lacks the negative flag.");

   a_event_not_lost: assert property (@(posedge clock) disable iff (reset)
      decode_event.valid |=> s1_valid_ff)
      else $error("Conversion result was dropped at the event register.");

endmodule

### tb/sv/tb_signed_pulse_width_thermometer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the signed pulse-width thermometer decoder.
// Drives requests, result stalls and register writes with random idling against a scoreboard.
// Depends on spwt_pkg and signed_pulse_width_thermometer.
module tb_signed_pulse_width_thermometer;
   import spwt_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int LONG_HOLD   = 400;
   localparam int SETTLE      = 8;

   typedef struct packed {
      logic [MAG_WIDTH-1:0] magnitude;
      logic                 negative;
      logic                 timed_out;
   } reading_t;

   class thermo_scoreboard;
      phase_type              phase;
      logic [COUNT_WIDTH-1:0] count;
      logic                   sign;
      logic [COUNT_WIDTH-1:0] start_timeout;
      logic [COUNT_WIDTH-1:0] max_pulse;
      reading_t               readings_due[$];
      int                     mismatches;

      function new();
         phase         = PHASE_IDLE;
         count         = '0;
         sign          = 1'b0;
         start_timeout = START_TIMEOUT_RESET;
         max_pulse     = MAX_PULSE_COUNT_RESET;
         mismatches    = 0;
      endfunction

      function void set_register(reg_index_type idx, logic [COUNT_WIDTH-1:0] value);
         if (idx == REG_START_TIMEOUT) begin
            start_timeout = value;
         end else begin
            max_pulse = value;
         end
      endfunction

      function int pending();
         return readings_due.size();
      endfunction

      function void conclude(int unsigned width, logic neg, logic tmo);
         int unsigned degrees;
         reading_t    reading;
         degrees           = (width * 19) / 100;
         reading.magnitude = MAG_WIDTH'(degrees);
         reading.negative  = neg;
         reading.timed_out = tmo;
         readings_due.push_back(reading);
         phase = PHASE_IDLE;
         count = '0;
      endfunction

      function void note_request(logic mode, logic plus, logic minus);
         logic                 active;
         logic [COUNT_WIDTH:0] k;
         active = plus | minus;
         if (mode) begin
            phase = PHASE_WAIT;
            count = '0;
            sign  = 1'b0;
            return;
         end
         case (phase)
            PHASE_WAIT: begin
               if (!active) begin
                  if (count >= start_timeout) conclude(0, 1'b1, 1'b1);
                  else count = count + 1'b1;
               end else begin
                  sign  = minus;
                  count = '0;
                  if (max_pulse == 0) conclude(0, sign, 1'b0);
                  else phase = PHASE_PULSE;
               end
            end
            PHASE_PULSE: begin
               k = {1'b0, count} + 1'b1;
               if (!active) conclude(k, sign, 1'b0);
               else if (k >= {1'b0, max_pulse}) conclude(0, sign, 1'b0);
               else count = k[COUNT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function void check_result(logic [MAG_WIDTH-1:0] magnitude, logic negative,
                                 logic timed_out);
         reading_t due;
         if (readings_due.size() == 0) begin
            $display("%0t: result with none outstanding: magnitude %0d negative %0b timed_out %0b",
                     $time, magnitude, negative, timed_out);
            mismatches++;
            return;
         end
         due = readings_due.pop_front();
         if (magnitude !== due.magnitude) begin
            $display("%0t: magnitude expected %0d actual %0d", $time, due.magnitude, magnitude);
            mismatches++;
         end
         if (negative !== due.negative) begin
            $display("%0t: negative expected %0b actual %0b", $time, due.negative, negative);
            mismatches++;
         end
         if (timed_out !== due.timed_out) begin
            $display("%0t: timed_out expected %0b actual %0b", $time, due.timed_out, timed_out);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_mode;
   logic                 req_plus_line;
   logic                 req_minus_line;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [MAG_WIDTH-1:0] rsp_magnitude;
   logic                 rsp_negative;
   logic                 rsp_timed_out;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [2:0]           paddr;
   logic [31:0]          pwdata;
   logic [31:0]          prdata;
   logic                 pready;

   thermo_scoreboard readings;
   bit               hold_requested;
   bit               quiet;
   int               sent_items;
   int               cycle_count;

   signed_pulse_width_thermometer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_plus_line  (req_plus_line),
      .req_minus_line (req_minus_line),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_negative   (rsp_negative),
      .rsp_timed_out  (rsp_timed_out),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         readings.check_result(rsp_magnitude, rsp_negative, rsp_timed_out);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   initial begin
      int stall;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_requested) begin
            hold_requested = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(negedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   task automatic send_request(logic mode, logic plus, logic minus);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_plus_line  <= plus;
      req_minus_line <= minus;
      do @(posedge clock); while (!req_ready);
      readings.note_request(mode, plus, minus);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic start_conversion();
      send_request(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_random_item();
      send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
   endtask

   // Lines are given as {plus, minus}; pulse_len counts active samples, the first included.
   task automatic run_conversion(int idles, int pulse_len, logic [1:0] first_lines);
      logic [1:0] lines;
      start_conversion();
      repeat (idles) send_request(1'b0, 1'b0, 1'b0);
      if (pulse_len > 0) begin
         send_request(1'b0, first_lines[1], first_lines[0]);
         repeat (pulse_len - 1) begin
            lines = 2'($urandom_range(1, 3));
            send_request(1'b0, lines[1], lines[0]);
         end
         send_request(1'b0, 1'b0, 1'b0);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (readings.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_register(reg_index_type idx, logic [COUNT_WIDTH-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(idx * 4);
      pwdata  <= {16'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readings.set_register(idx, value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {16'd0, value}) begin
         $display("%0t: register %0d read expected %0d actual %0d", $time, idx, value, prdata);
         readings.mismatches++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(logic [COUNT_WIDTH-1:0] timeout, logic [COUNT_WIDTH-1:0] longest);
      wait_drained();
      write_register(REG_START_TIMEOUT, timeout);
      write_register(REG_MAX_PULSE_COUNT, longest);
   endtask

   task automatic random_phase(int n, int idle_cap, int pulse_cap);
      int goal;
      int r;
      goal = sent_items + n;
      while (sent_items < goal) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            run_conversion($urandom_range(0, idle_cap), $urandom_range(0, pulse_cap),
                           2'($urandom_range(1, 3)));
         end else if (r < 85) begin
            start_conversion();
            repeat ($urandom_range(0, 4)) send_random_item();
         end else begin
            send_random_item();
         end
      end
   endtask

   initial begin
      int timeout;
      int longest;
      readings       = new();
      hold_requested = 1'b0;
      quiet          = 1'b0;
      sent_items     = 0;
      cycle_count    = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = 1'b0;
      req_plus_line  = 1'b0;
      req_minus_line = 1'b0;
      rsp_ready      = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Samples with nothing armed, signed pulses, both lines at once and a restart.
      send_request(1'b0, 1'b1, 1'b0);
      send_request(1'b0, 1'b0, 1'b1);
      run_conversion(2, 3, 2'b10);
      run_conversion(0, 6, 2'b01);
      run_conversion(1, 1, 2'b11);
      start_conversion();
      send_request(1'b0, 1'b1, 1'b0);
      run_conversion(0, 2, 2'b01);

      configure(16'd1, 16'd1);
      run_conversion(2, 0, 2'b00);
      run_conversion(0, 2, 2'b10);
      hold_requested = 1'b1;
      random_phase(150, 3, 3);

      configure(16'd0, 16'd0);
      run_conversion(0, 1, 2'b01);
      run_conversion(1, 0, 2'b00);
      random_phase(100, 2, 2);

      configure(16'd65535, 16'd65535);
      run_conversion(120, 0, 2'b00);
      run_conversion(0, 150, 2'b10);
      random_phase(100, 20, 20);

      for (int i = 0; i < 6; i++) begin
         timeout = (i == 2) ? $urandom_range(0, 65535) : $urandom_range(0, 25);
         longest = $urandom_range(1, 40);
         configure(16'(timeout), 16'(longest));
         quiet = (i == 3);
         if (i == 4) hold_requested = 1'b1;
         random_phase(120, (timeout > 25 ? 25 : timeout + 2), longest + 2);
      end
      quiet = 1'b0;

      wait_drained();
      if (readings.mismatches == 0 && readings.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
design/spwt_pkg.sv
design/spwt_decoder.sv
design/signed_pulse_width_thermometer.sv
tb/sv/tb_signed_pulse_width_thermometer.sv
